[rtl/cmm_pkg.sv]
// Shared types and constants for the complex matrix multiply block.
// Holds opcodes, register indexes, status codes and the pipeline tag struct.
// No dependencies.
`default_nettype none

package cmm_pkg;

  localparam int ACC_W = 37;
  localparam int IDX_W = 4;
  localparam int DIM_W = 5;

  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;
  localparam logic [1:0] REG_CONJ_B    = 2'd3;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Control that travels alongside one multiply-accumulate step.
  typedef struct packed {
    logic             vld;
    logic             first_k;
    logic             last_k;
    logic [IDX_W-1:0] col;
    logic             last_col;
  } cmm_tag_t;

endpackage

`default_nettype wire

[rtl/cmm_store.sv]
// Element stores for matrices A and B: one write port shared by both, one read port each.
// Synchronous memories with registered read data. Uses no package.
`default_nettype none

module cmm_store #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 32,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              a_we_i,
  input  wire logic              b_we_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic [ADDR_W-1:0] rd_a_addr_i,
  input  wire logic [ADDR_W-1:0] rd_b_addr_i,
  output logic      [DATA_W-1:0] rd_a_data_o,
  output logic      [DATA_W-1:0] rd_b_data_o
);

  logic [DATA_W-1:0] a_mem [DEPTH];
  logic [DATA_W-1:0] b_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (a_we_i) begin
      a_mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_data_o <= a_mem[rd_a_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (b_we_i) begin
      b_mem[wr_addr_i] <= wr_data_i;
    end
    rd_b_data_o <= b_mem[rd_b_addr_i];
  end

endmodule

`default_nettype wire

[rtl/cmm_mac.sv]
// Complex multiply-accumulate pipeline: products, combine, accumulate over the inner dimension.
// Depends on cmm_pkg for the tag struct and accumulator width.
`default_nettype none

module cmm_mac import cmm_pkg::*; #(
  parameter int SW = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmm_tag_t                tag_i,
  input  wire logic                    conj_i,
  input  wire logic [2*SW-1:0]         a_data_i,
  input  wire logic [2*SW-1:0]         b_data_i,
  output cmm_tag_t                     res_tag_o,
  output logic signed [ACC_W-1:0]      sum_re_o,
  output logic signed [ACC_W-1:0]      sum_im_o
);

  cmm_tag_t s1_q, s2_q, s3_q;

  logic signed [SW-1:0]   a_re, a_im, b_re, b_im;
  logic signed [2*SW-1:0] rr_q, ii_q, ri_q, ir_q;
  logic signed [ACC_W-1:0] re_q, im_q, re_d, im_d;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q, acc_re_d, acc_im_d;

  assign a_re = a_data_i[SW-1:0];
  assign a_im = a_data_i[2*SW-1:SW];
  assign b_re = b_data_i[SW-1:0];
  assign b_im = b_data_i[2*SW-1:SW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q <= tag_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // Partial products of the four cross terms.
  always_ff @(posedge clk_i) begin
    rr_q <= a_re * b_re;
    ii_q <= a_im * b_im;
    ri_q <= a_re * b_im;
    ir_q <= a_im * b_re;
  end

  always_comb begin
    if (conj_i) begin
      re_d = ACC_W'(rr_q) + ACC_W'(ii_q);
      im_d = ACC_W'(ir_q) - ACC_W'(ri_q);
    end else begin
      re_d = ACC_W'(rr_q) - ACC_W'(ii_q);
      im_d = ACC_W'(ir_q) + ACC_W'(ri_q);
    end
  end

  always_ff @(posedge clk_i) begin
    re_q <= re_d;
    im_q <= im_d;
  end

  // Restart the sum on the first inner step of each column.
  assign acc_re_d = s3_q.first_k ? re_q : acc_re_q + re_q;
  assign acc_im_d = s3_q.first_k ? im_q : acc_im_q + im_q;

  always_ff @(posedge clk_i) begin
    if (s3_q.vld) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  assign res_tag_o = s3_q;
  assign sum_re_o  = acc_re_d;
  assign sum_im_o  = acc_im_d;

  a_stage_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_q.vld |-> $past(s1_q.vld, 2))
    else $error("accumulate stage valid without a matching read stage");

endmodule

`default_nettype wire

[rtl/complex_matrix_multiply.sv]
// Complex matrix multiply: C = A*B or A*conj(B), rows of C emitted on request.
// Writes of A or B elements never raise busy_o.
// A row compute raises busy_o until the last element of the row is registered; the elements
// appear in column order, each summed over the inner dimension (one MAC per cycle).
// A row index out of range gives one error beat in the cycle after start. Results cannot stall.
// Reset clears the configuration to 1/1/1/no-conjugate; the A and B stores are not cleared.
`default_nettype none

module complex_matrix_multiply import cmm_pkg::*; #(
  parameter int MAX_DIM      = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [DIM_W-1:0]               cfg_data_i,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [1:0]                     opcode_i,
  input  wire logic [IDX_W-1:0]               row_index_i,
  input  wire logic [IDX_W-1:0]               col_index_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] elem_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] elem_im_i,
  output logic                                result_valid_o,
  output logic signed [ACC_W-1:0]             prod_re_o,
  output logic signed [ACC_W-1:0]             prod_im_o,
  output logic [IDX_W-1:0]                    out_col_o,
  output logic                                last_in_row_o,
  output logic                                status_o
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 2 * SAMPLE_WIDTH;

  function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return v;
  endfunction

  logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic             conj_b_q;
  logic [DIM_W-1:0] ra, nk, cb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_W'(1);
      inner_dim_q <= DIM_W'(1);
      cols_b_q    <= DIM_W'(1);
      conj_b_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROWS_A:    rows_a_q    <= cfg_data_i;
        REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        REG_COLS_B:    cols_b_q    <= cfg_data_i;
        REG_CONJ_B:    conj_b_q    <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  assign ra = dim_eff(rows_a_q);
  assign nk = dim_eff(inner_dim_q);
  assign cb = dim_eff(cols_b_q);

  // Command decode
  logic accept, row_in_a, we_a, we_b, compute_ok, error_hit;
  logic [ADDR_W-1:0] wr_addr;

  assign accept   = start_i && !busy_o;
  assign row_in_a = {1'b0, row_index_i} < ra;
  assign we_a = accept && (opcode_i == OP_WRITE_A) && row_in_a
             && ({1'b0, col_index_i} < nk);
  assign we_b = accept && (opcode_i == OP_WRITE_B) && ({1'b0, row_index_i} < nk)
             && ({1'b0, col_index_i} < cb);
  assign compute_ok = accept && (opcode_i == OP_COMPUTE) && row_in_a;
  assign error_hit  = accept && (opcode_i == OP_COMPUTE) && !row_in_a;
  assign wr_addr = ADDR_W'(32'(row_index_i) * MAX_DIM + 32'(col_index_i));

  // Issue sequencer: walk k fastest, then c.
  logic busy_q, issue_q;
  logic [IDX_W-1:0] row_q;
  logic [DIM_W-1:0] k_q, c_q;
  logic             k_last, c_last;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  cmm_tag_t issue_tag, res_tag;
  logic emit;

  assign k_last = (k_q == nk - DIM_W'(1));
  assign c_last = (c_q == cb - DIM_W'(1));

  assign rd_a_addr = ADDR_W'(32'(row_q) * MAX_DIM + 32'(k_q));
  assign rd_b_addr = ADDR_W'(32'(k_q) * MAX_DIM + 32'(c_q));

  assign issue_tag.vld      = issue_q;
  assign issue_tag.first_k  = (k_q == '0);
  assign issue_tag.last_k   = k_last;
  assign issue_tag.col      = c_q[IDX_W-1:0];
  assign issue_tag.last_col = c_last;

  assign emit = res_tag.vld && res_tag.last_k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      issue_q <= 1'b0;
      row_q   <= '0;
      k_q     <= '0;
      c_q     <= '0;
    end else begin
      if (compute_ok) begin
        busy_q  <= 1'b1;
        issue_q <= 1'b1;
        row_q   <= row_index_i;
        k_q     <= '0;
        c_q     <= '0;
      end else begin
        if (issue_q) begin
          if (k_last) begin
            k_q <= '0;
            if (c_last) begin
              issue_q <= 1'b0;
            end else begin
              c_q <= c_q + DIM_W'(1);
            end
          end else begin
            k_q <= k_q + DIM_W'(1);
          end
        end
        // drop busy as the last beat of the row is registered
        if (emit && res_tag.last_col) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o = busy_q;

  logic [DATA_W-1:0] rd_a_data, rd_b_data;
  logic signed [ACC_W-1:0] sum_re, sum_im;

  cmm_store #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i       (clk_i),
    .a_we_i      (we_a),
    .b_we_i      (we_b),
    .wr_addr_i   (wr_addr),
    .wr_data_i   ({elem_im_i, elem_re_i}),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data)
  );

  cmm_mac #(
    .SW (SAMPLE_WIDTH)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (issue_tag),
    .conj_i    (conj_b_q),
    .a_data_i  (rd_a_data),
    .b_data_i  (rd_b_data),
    .res_tag_o (res_tag),
    .sum_re_o  (sum_re),
    .sum_im_o  (sum_im)
  );

  // Result beat register
  logic                    result_valid_q;
  logic signed [ACC_W-1:0] prod_re_q, prod_im_q;
  logic [IDX_W-1:0]        out_col_q;
  logic                    last_q, status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= error_hit || emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (error_hit) begin
      prod_re_q <= '0;
      prod_im_q <= '0;
      out_col_q <= '0;
      last_q    <= 1'b1;
      status_q  <= STATUS_RANGE;
    end else if (emit) begin
      prod_re_q <= sum_re;
      prod_im_q <= sum_im;
      out_col_q <= res_tag.col;
      last_q    <= res_tag.last_col;
      status_q  <= STATUS_OK;
    end
  end

  assign result_valid_o = result_valid_q;
  assign prod_re_o      = prod_re_q;
  assign prod_im_o      = prod_im_q;
  assign out_col_o      = out_col_q;
  assign last_in_row_o  = last_q;
  assign status_o       = status_q;

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> result_valid_o && last_in_row_o && (status_o == STATUS_OK))
    else $error("busy dropped without a final row beat");

  a_issue_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q |-> busy_q)
    else $error("issuing reads while not busy");

  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == STATUS_RANGE) |-> last_in_row_o && (out_col_o == '0))
    else $error("error beat not marked as a single last beat");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !issue_q |=> !issue_q)
    else $error("issue restarted while draining the pipeline");

endmodule

`default_nettype wire

[sim/tb_complex_matrix_multiply.sv]
// Testbench for complex_matrix_multiply: mirrors the A/B stores and registers, predicts
// every product element of each row compute and checks each beat as it leaves the block.
// Depends on rtl/cmm_pkg.sv and rtl/complex_matrix_multiply.sv, which needs rtl/cmm_store.sv and rtl/cmm_mac.sv.
`default_nettype none

module tb_complex_matrix_multiply;
  import cmm_pkg::*;

  localparam int MAX_DIM = 16;
  localparam int SW      = 16;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [SW-1:0] Q_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] Q_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef struct packed {
    logic [1:0]             op;
    logic [IDX_W-1:0]       row;
    logic [IDX_W-1:0]       col;
    logic signed [SW-1:0]   re;
    logic signed [SW-1:0]   im;
  } cmd_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
    logic [IDX_W-1:0]        col;
    logic                    last;
    logic                    status;
  } prod_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [DIM_W-1:0] cfg_data_i;
  logic start_i;
  logic busy_o;
  logic [1:0] opcode_i;
  logic [IDX_W-1:0] row_index_i;
  logic [IDX_W-1:0] col_index_i;
  logic signed [SW-1:0] elem_re_i;
  logic signed [SW-1:0] elem_im_i;
  logic result_valid_o;
  logic signed [ACC_W-1:0] prod_re_o;
  logic signed [ACC_W-1:0] prod_im_o;
  logic [IDX_W-1:0] out_col_o;
  logic last_in_row_o;
  logic status_o;

  // Mirrored state of the block
  logic signed [SW-1:0] a_re [DEPTH];
  logic signed [SW-1:0] a_im [DEPTH];
  logic signed [SW-1:0] b_re [DEPTH];
  logic signed [SW-1:0] b_im [DEPTH];
  bit a_set [DEPTH];
  bit b_set [DEPTH];
  logic [DIM_W-1:0] rows_a_q = 5'd1;
  logic [DIM_W-1:0] inner_q  = 5'd1;
  logic [DIM_W-1:0] cols_b_q = 5'd1;
  logic conj_q = 1'b0;

  prod_t due_products [$];
  prod_t want;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  bit gaps_on = 1'b1;

  complex_matrix_multiply #(
    .MAX_DIM      (MAX_DIM),
    .SAMPLE_WIDTH (SW)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .elem_re_i      (elem_re_i),
    .elem_im_i      (elem_im_i),
    .result_valid_o (result_valid_o),
    .prod_re_o      (prod_re_o),
    .prod_im_o      (prod_im_o),
    .out_col_o      (out_col_o),
    .last_in_row_o  (last_in_row_o),
    .status_o       (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned dim_eff(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic cmd_t beat(input logic [1:0] op, input int unsigned row,
                                input int unsigned col, input logic signed [SW-1:0] re,
                                input logic signed [SW-1:0] im);
    cmd_t c;
    c.op  = op;
    c.row = row[IDX_W-1:0];
    c.col = col[IDX_W-1:0];
    c.re  = re;
    c.im  = im;
    return c;
  endfunction

  function automatic logic signed [SW-1:0] elem_val();
    case ($urandom_range(0, 7))
      0: return Q_MIN;
      1: return Q_MAX;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned s;
    s = $urandom_range(0, 9);
    if (s < 6) return DIM_W'($urandom_range(1, 4));
    if (s < 8) return DIM_W'($urandom_range(5, 8));
    if (s == 8) return $urandom_range(0, 1) ? 5'd0 : 5'd16;
    return DIM_W'($urandom_range(9, 31));
  endfunction

  // Apply one accepted beat to the mirrored stores and queue the product row or error beat it yields.
  task automatic mirror_item(input cmd_t c);
    int unsigned ra, nk, cb, addr, ai, bi;
    longint acc_re, acc_im, ar, aim, br, bim, rr, ii, ri, ir;
    prod_t p;
    ra = dim_eff(rows_a_q);
    nk = dim_eff(inner_q);
    cb = dim_eff(cols_b_q);
    addr = c.row * MAX_DIM + c.col;
    case (c.op)
      OP_WRITE_A: begin
        if (c.row < ra && c.col < nk) begin
          a_re[addr] = c.re;
          a_im[addr] = c.im;
          a_set[addr] = 1'b1;
        end
      end
      OP_WRITE_B: begin
        if (c.row < nk && c.col < cb) begin
          b_re[addr] = c.re;
          b_im[addr] = c.im;
          b_set[addr] = 1'b1;
        end
      end
      OP_COMPUTE: begin
        if (c.row >= ra) begin
          p.re = '0;
          p.im = '0;
          p.col = '0;
          p.last = 1'b1;
          p.status = STATUS_RANGE;
          due_products.push_back(p);
        end else begin
          for (int unsigned col = 0; col < cb; col++) begin
            acc_re = 0;
            acc_im = 0;
            for (int unsigned k = 0; k < nk; k++) begin
              ai = c.row * MAX_DIM + k;
              bi = k * MAX_DIM + col;
              ar = a_re[ai];
              aim = a_im[ai];
              br = b_re[bi];
              bim = b_im[bi];
              rr = ar * br;
              ii = aim * bim;
              ri = ar * bim;
              ir = aim * br;
              if (conj_q) begin
                acc_re += rr + ii;
                acc_im += ir - ri;
              end else begin
                acc_re += rr - ii;
                acc_im += ir + ri;
              end
            end
            p.re = acc_re[ACC_W-1:0];
            p.im = acc_im[ACC_W-1:0];
            p.col = col[IDX_W-1:0];
            p.last = (col + 1 == cb);
            p.status = STATUS_OK;
            due_products.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic pause(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Drive one beat and hold it until the block takes it; start stays high for the next beat.
  task automatic issue(input cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) pause($urandom_range(1, 6));
    end
    burst_left--;
    start_i     <= 1'b1;
    opcode_i    <= c.op;
    row_index_i <= c.row;
    col_index_i <= c.col;
    elem_re_i   <= c.re;
    elem_im_i   <= c.im;
    do @(posedge clk_i); while (busy_o);
    mirror_item(c);
  endtask

  // Drop start, drain every pending product element and let the pipeline empty.
  task automatic settle();
    pause(1);
    while (due_products.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_ROWS_A:    rows_a_q = val;
      REG_INNER_DIM: inner_q = val;
      REG_COLS_B:    cols_b_q = val;
      REG_CONJ_B:    conj_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] nk,
                          input logic [DIM_W-1:0] cb, input logic cj);
    settle();
    write_reg(REG_ROWS_A, ra);
    write_reg(REG_INNER_DIM, nk);
    write_reg(REG_COLS_B, cb);
    write_reg(REG_CONJ_B, {{(DIM_W-1){1'b0}}, cj});
    cfg_we_i <= 1'b0;
  endtask

  // Write every entry that a row compute under the current sizes would read but is still empty.
  task automatic fill_missing();
    int unsigned ra, nk, cb;
    ra = dim_eff(rows_a_q);
    nk = dim_eff(inner_q);
    cb = dim_eff(cols_b_q);
    for (int unsigned r = 0; r < ra; r++)
      for (int unsigned k = 0; k < nk; k++)
        if (!a_set[r * MAX_DIM + k]) issue(beat(OP_WRITE_A, r, k, elem_val(), elem_val()));
    for (int unsigned k = 0; k < nk; k++)
      for (int unsigned c = 0; c < cb; c++)
        if (!b_set[k * MAX_DIM + c]) issue(beat(OP_WRITE_B, k, c, elem_val(), elem_val()));
  endtask

  task automatic test_reset_defaults();
    issue(beat(OP_WRITE_A, 0, 0, Q_MIN, Q_MIN));
    issue(beat(OP_WRITE_B, 0, 0, Q_MIN, Q_MIN));
    issue(beat(OP_COMPUTE, 0, 15, Q_MAX, Q_MIN));
    issue(beat(OP_COMPUTE, 15, 0, '0, '0));
    issue(beat(OP_UNUSED, 15, 15, Q_MAX, Q_MAX));
    // out-of-range writes must leave the stores alone
    issue(beat(OP_WRITE_A, 0, 1, Q_MAX, Q_MAX));
    issue(beat(OP_WRITE_A, 1, 0, Q_MAX, Q_MAX));
    issue(beat(OP_WRITE_B, 1, 0, Q_MAX, Q_MAX));
    issue(beat(OP_WRITE_B, 0, 1, Q_MAX, Q_MAX));
    issue(beat(OP_COMPUTE, 0, 0, '0, '0));
    issue(beat(OP_WRITE_B, 0, 0, Q_MAX, Q_MIN));
    issue(beat(OP_COMPUTE, 0, 0, '0, '0));
  endtask

  task automatic test_dim_clamping();
    // zero sizes act as one
    set_dims(5'd0, 5'd0, 5'd0, 1'b1);
    issue(beat(OP_COMPUTE, 0, 0, '0, '0));
    issue(beat(OP_COMPUTE, 1, 0, '0, '0));
    issue(beat(OP_WRITE_A, 0, 1, Q_MIN, Q_MAX));
    issue(beat(OP_COMPUTE, 0, 0, '0, '0));
    // oversized values clamp to the full 16
    set_dims(5'd31, 5'd1, 5'd31, 1'b0);
    fill_missing();
    issue(beat(OP_COMPUTE, 15, 0, '0, '0));
    issue(beat(OP_COMPUTE, 0, 0, '0, '0));
  endtask

  task automatic test_peak_sums();
    set_dims(5'd1, 5'd16, 5'd1, 1'b0);
    for (int unsigned k = 0; k < MAX_DIM; k++) begin
      issue(beat(OP_WRITE_A, 0, k, Q_MIN, Q_MIN));
      issue(beat(OP_WRITE_B, k, 0, Q_MIN, Q_MIN));
    end
    issue(beat(OP_COMPUTE, 0, 0, '0, '0));
    set_dims(5'd1, 5'd16, 5'd1, 1'b1);
    issue(beat(OP_COMPUTE, 0, 0, '0, '0));
    for (int unsigned k = 0; k < MAX_DIM; k++)
      issue(beat(OP_WRITE_B, k, 0, Q_MAX, Q_MIN));
    issue(beat(OP_COMPUTE, 0, 0, '0, '0));
    set_dims(5'd1, 5'd16, 5'd1, 1'b0);
    issue(beat(OP_COMPUTE, 0, 0, '0, '0));
  endtask

  task automatic test_random_phases();
    int unsigned done, sel, ra, nk, cb;
    for (int ph = 0; ph < 6; ph++) begin
      set_dims(pick_dim(), pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
      gaps_on = ($urandom_range(0, 3) != 0);
      fill_missing();
      ra = dim_eff(rows_a_q);
      nk = dim_eff(inner_q);
      cb = dim_eff(cols_b_q);
      done = 0;
      while (done < 30) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          issue(beat(OP_COMPUTE, $urandom_range(0, ra - 1), $urandom_range(0, 15),
                     elem_val(), elem_val()));
          done++;
        end else if (sel < 55 && ra < MAX_DIM) begin
          issue(beat(OP_COMPUTE, $urandom_range(ra, 15), $urandom_range(0, 15),
                     elem_val(), elem_val()));
          done++;
        end else if (sel < 72) begin
          issue(beat(OP_WRITE_A, $urandom_range(0, ra - 1), $urandom_range(0, nk - 1),
                     elem_val(), elem_val()));
          done++;
        end else if (sel < 89) begin
          issue(beat(OP_WRITE_B, $urandom_range(0, nk - 1), $urandom_range(0, cb - 1),
                     elem_val(), elem_val()));
          done++;
        end else begin
          // noise: unused opcode or writes anywhere in the address space
          issue(beat(2'($urandom_range(0, 1)) | (sel[0] ? OP_UNUSED : 2'd0),
                     $urandom_range(0, 15), $urandom_range(0, 15), elem_val(), elem_val()));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (due_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected product beat: re %0d im %0d col %0d", prod_re_o, prod_im_o,
                   out_col_o);
      end else begin
        want = due_products.pop_front();
        if (prod_re_o !== want.re || prod_im_o !== want.im || out_col_o !== want.col ||
            last_in_row_o !== want.last || status_o !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"product mismatch: re %0d/%0d im %0d/%0d col %0d/%0d",
                      " last %0b/%0b st %0b/%0b"},
                     want.re, prod_re_o, want.im, prod_im_o, want.col, out_col_o,
                     want.last, last_in_row_o, want.status, status_o);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_ROWS_A;
    cfg_data_i  <= '0;
    start_i     <= 1'b0;
    opcode_i    <= OP_UNUSED;
    row_index_i <= '0;
    col_index_i <= '0;
    elem_re_i   <= '0;
    elem_im_i   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_dim_clamping();
    test_peak_sums();
    test_random_phases();
    settle();
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
